### hdl/modular_exponentiation_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation unit
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the
// following cycle.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths and default operand width for the modular exponentiation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of each operand field on the stream ports.
  localparam int unsigned MEXP_FIELD_W = 64;

  // Default number of operand bits that take part in the computation.
  localparam int unsigned MEXP_WIDTH = 64;

  // Packed input beat: base, exponent, modulus from the lowest bit up.
  localparam int unsigned MEXP_IN_W = 3 * MEXP_FIELD_W;

endpackage

### hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// with one bit-serial interleaved modular multiplier shared by all steps.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat on the s_axis channel carries base, exponent and modulus.
//   Only the low WIDTH bits of each field are used. One result beat per input
//   leaves on the m_axis channel: the power in tdata and an error flag in
//   tuser, which is set (with a zero result) when the modulus is zero.
// Operation:
//   The multiplier consumes one multiplier bit per cycle, MSB first. The base
//   is first reduced modulo the modulus. Each exponent bit then takes a
//   decision step, a multiply into the running result for a set bit, and a
//   squaring of the base. Scanning stops after the highest set exponent bit.
//   A zero modulus skips the computation and goes straight to finish. One item
//   is worked on at a time.
// Reset and stalls:
//   Reset returns the unit to idle with no result pending. A finished result
//   waits in the output register while the receiver stalls; a new beat may
//   be accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_unit #(
  parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream; tdata fields from bit 0: base_value, exponent, modulus.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mexp_pkg::MEXP_IN_W-1:0]    s_axis_tdata,
  // Output stream; tdata: power_result. tuser: modulus_error.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mexp_pkg::MEXP_FIELD_W-1:0] m_axis_tdata,
  output logic                              m_axis_tuser
);

  import mexp_pkg::*;

  `include "modular_exponentiation_unit_macros.svh"

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DECIDE,
    ST_MUL_ACC,
    ST_MUL_SQR,
    ST_FINISH
  } state_e;

  // Control and output registers.
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [MEXP_FIELD_W-1:0] out_data_q, out_data_d;
  logic                    out_err_q, out_err_d;

  // Datapath registers.
  logic [WIDTH-1:0] mod_q, mod_d;     // modulus
  logic [WIDTH-1:0] exp_q, exp_d;     // exponent, shifted right per round
  logic [WIDTH-1:0] base_q, base_d;   // running base power, reduced
  logic [WIDTH-1:0] acc_q, acc_d;     // running result
  logic             err_q, err_d;     // zero modulus seen
  logic [WIDTH-1:0] mm_q, mm_d;       // multiplier partial result
  logic [WIDTH-1:0] mcand_q, mcand_d; // multiplicand
  logic [WIDTH-1:0] mplier_q, mplier_d; // multiplier bits, MSB first

  // Input field extraction.
  logic [WIDTH-1:0] in_base, in_exp, in_mod;
  assign in_base = s_axis_tdata[WIDTH-1:0];
  assign in_exp  = s_axis_tdata[MEXP_FIELD_W +: WIDTH];
  assign in_mod  = s_axis_tdata[2*MEXP_FIELD_W +: WIDTH];

  // One interleaved step: r = (2*mm + bit*mcand) mod m, with the sum below 3m.
  logic [WIDTH+1:0] step_sum, step_m1, step_m2, step_r;
  logic [WIDTH-1:0] step_val;
  logic             last_bit;

  always_comb begin
    step_sum = {1'b0, mm_q, 1'b0}
             + (mplier_q[WIDTH-1] ? {2'b00, mcand_q} : '0);
    step_m1  = {2'b00, mod_q};
    step_m2  = {1'b0, mod_q, 1'b0};
    if (step_sum >= step_m2) begin
      step_r = step_sum - step_m2;
    end else if (step_sum >= step_m1) begin
      step_r = step_sum - step_m1;
    end else begin
      step_r = step_sum;
    end
    step_val = step_r[WIDTH-1:0];
  end

  assign last_bit = (cnt_q == '0);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;
    mod_d       = mod_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    err_d       = err_q;
    mm_d        = mm_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;

    // The pending result leaves when the receiver takes it.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mod_d    = in_mod;
          exp_d    = in_exp;
          // Reduce the base first: multiply by one against the raw base bits.
          mm_d     = '0;
          mcand_d  = WIDTH'(1);
          mplier_d = in_base;
          cnt_d    = CNT_LAST;
          if (in_mod == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            acc_d   = WIDTH'(1);
            err_d   = 1'b0;
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        mm_d     = step_val;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (last_bit) begin
          base_d  = step_val;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        mm_d     = '0;
        mplier_d = base_q;
        cnt_d    = CNT_LAST;
        if (exp_q == '0) begin
          state_d = ST_FINISH;
        end else if (exp_q[0]) begin
          mcand_d = acc_q;
          state_d = ST_MUL_ACC;
        end else begin
          mcand_d = base_q;
          state_d = ST_MUL_SQR;
        end
      end
      ST_MUL_ACC: begin
        mm_d     = step_val;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (last_bit) begin
          acc_d    = step_val;
          mm_d     = '0;
          mcand_d  = base_q;
          mplier_d = base_q;
          cnt_d    = CNT_LAST;
          state_d  = ST_MUL_SQR;
        end
      end
      ST_MUL_SQR: begin
        mm_d     = step_val;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (last_bit) begin
          base_d  = step_val;
          exp_d   = exp_q >> 1;
          state_d = ST_DECIDE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = MEXP_FIELD_W'(acc_q);
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_err_q   <= out_err_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    mod_q    <= mod_d;
    exp_q    <= exp_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    err_q    <= err_d;
    mm_q     <= mm_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  // Checks on the sequencer and the multiplier.
  `MEXP_ASSERT_SAME(a_mm_in_range, clk_i, rst_ni,
    (state_q == ST_REDUCE || state_q == ST_MUL_ACC || state_q == ST_MUL_SQR),
    (mm_q < mod_q), "partial product not reduced below the modulus")
  `MEXP_ASSERT_SAME(a_mul_nonzero_mod, clk_i, rst_ni,
    (state_q == ST_MUL_ACC || state_q == ST_MUL_SQR), (mod_q != '0),
    "multiplication started with a zero modulus")
  `MEXP_ASSERT_SAME(a_err_zero_result, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser), (m_axis_tdata == '0),
    "error beat carries a nonzero result")
  `MEXP_ASSERT_NEXT(a_zero_mod_finish, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready && (in_mod == '0)),
    (state_q == ST_FINISH && err_q), "zero modulus did not go straight to finish")

endmodule
